// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NPME_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define NPME_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/npme_pkg.sv -----
// Types and constants of the nearest point mean error block.
// No dependencies.
package npme_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 17;
    localparam int IDX_W   = 4;
    localparam int PIDX_W  = 10;
    localparam int SUM_W   = 27;
    localparam int DVD_W   = SUM_W + 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic                      restart;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  nearest_index;
        logic [PIDX_W-1:0] point_index;
        logic              no_reference;
        logic [DIST_W-1:0] mean_distance;
        logic              mean_valid;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_POST,
        ST_DIVST,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic sqrt_start;
        logic post;
        logic div_start;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic ref_empty;
        logic scan_last;
        logic pipe_busy;
        logic sqrt_done;
        logic last;
        logic div_done;
    } dp_status_t;

endpackage

// ----- hw/rtl/npme_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
module npme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/npme_ctrl.sv -----
// Controller state machine of the nearest point mean error block.
// Depends on npme_pkg.
module npme_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output npme_pkg::dp_cmd_t    cmd,
    input  npme_pkg::dp_status_t status
);
    import npme_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.op == OP_QUERY)
                    begin
                        state_next = status.ref_empty ? ST_POST : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                cmd.post   = 1'b1;
                state_next = status.last ? ST_DIVST : ST_OUT;
            end
            ST_DIVST:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & result_stall);
    assign result_valid   = out_valid_reg;

endmodule

// ----- hw/rtl/npme_datapath.sv -----
// Datapath: reference store, distance pipeline, square root and divider units.
// Depends on npme_pkg and npme_ram.
module npme_datapath #(
    parameter int REF_DEPTH   = 16,
    parameter int QUERY_MAX   = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npme_pkg::item_t      item,
    input  npme_pkg::dp_cmd_t    cmd,
    output npme_pkg::dp_status_t status,
    output npme_pkg::result_t    result
);
    import npme_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int IW  = $clog2(REF_DEPTH > 1 ? REF_DEPTH : 2);
    localparam int CNW = $clog2(REF_DEPTH + 1);
    localparam int DW  = CW + 1;
    localparam int SQ2 = 2 * DW;
    localparam int D2W = SQ2 + 1;
    localparam int SQN = (D2W + 1) / 2;
    localparam int SQW = 2 * SQN;
    localparam int RW  = SQN + 2;
    localparam int SCW = $clog2(SQN + 1);
    localparam int QCW = $clog2(QUERY_MAX + 1);
    localparam int DCW = $clog2(DVD_W + 1);

    // reference store
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [2*CW-1:0]   ram_rdata;
    logic [CNW-1:0]    ref_count_reg;
    logic signed [CW-1:0] in_x, in_y;

    assign in_x      = CW'(item.coord_x);
    assign in_y      = CW'(item.coord_y);
    assign ram_we    = cmd.accept && (item.op == OP_LOAD)
                       && (item.restart || (ref_count_reg < CNW'(REF_DEPTH)));
    assign ram_waddr = item.restart ? '0 : ref_count_reg[IW-1:0];

    logic [IW-1:0] scan_idx_reg;

    npme_ram #(
        .WIDTH (2 * CW),
        .DEPTH (REF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_x, in_y}),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // query registers
    logic signed [CW-1:0] qx_reg, qy_reg;
    logic                 last_reg, none_reg;

    // distance pipeline
    logic            rd_v_reg, ab_v_reg, sq_v_reg;
    logic [IW-1:0]   rd_idx_reg, ab_idx_reg, sq_idx_reg, best_idx_reg;
    logic [DW-1:0]   dx_reg, dy_reg;
    logic [SQ2-1:0]  sqx_reg, sqy_reg;
    logic [D2W-1:0]  best_reg, d2;
    logic signed [DW-1:0] diff_x, diff_y;
    logic signed [CW-1:0] ref_x, ref_y;

    assign ref_x  = ram_rdata[2*CW-1:CW];
    assign ref_y  = ram_rdata[CW-1:0];
    assign diff_x = DW'(qx_reg) - DW'(ref_x);
    assign diff_y = DW'(qy_reg) - DW'(ref_y);
    assign d2     = D2W'(sqx_reg) + D2W'(sqy_reg);

    // square root
    logic [SQW-1:0] sq_src_reg;
    logic [SQN-1:0] sq_root_reg;
    logic [RW-1:0]  sq_rem_reg, sq_rem_sh, sq_trial;
    logic [SCW-1:0] sq_cnt_reg;

    assign sq_rem_sh = {sq_rem_reg[RW-3:0], sq_src_reg[SQW-1 -: 2]};
    assign sq_trial  = {sq_root_reg, 2'b01};

    // accumulation and mean
    logic [SUM_W-1:0]  sum_reg;
    logic [QCW-1:0]    qc_reg;
    logic [SQN:0]      dist_reg, dist_calc;
    logic [PIDX_W-1:0] pidx_reg;
    logic [DVD_W-1:0]  sum_add;
    logic [DVD_W-1:0]  dv_quo_reg;
    logic [QCW:0]      dv_rem_reg, dv_rem_sh;
    logic [QCW-1:0]    dv_div_reg;
    logic [DCW-1:0]    dv_cnt_reg;
    logic              mvalid_reg;

    assign dist_calc = none_reg ? '0
                       : (SQN+1)'(sq_root_reg)
                         + (SQN+1)'(sq_rem_reg > RW'(sq_root_reg));
    assign sum_add   = DVD_W'(sum_reg) + DVD_W'(dist_calc);
    assign dv_rem_sh = {dv_rem_reg[QCW-1:0], dv_quo_reg[DVD_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            scan_idx_reg  <= '0;
            rd_v_reg      <= 1'b0;
            ab_v_reg      <= 1'b0;
            sq_v_reg      <= 1'b0;
            sq_cnt_reg    <= '0;
            dv_cnt_reg    <= '0;
            sum_reg       <= '0;
            qc_reg        <= '0;
        end
        else
        begin
            rd_v_reg <= cmd.scan_issue;
            ab_v_reg <= rd_v_reg;
            sq_v_reg <= ab_v_reg;

            if (cmd.accept)
            begin
                scan_idx_reg <= '0;
                if (item.op == OP_LOAD)
                begin
                    if (item.restart)
                    begin
                        ref_count_reg <= CNW'(1);
                    end
                    else if (ref_count_reg < CNW'(REF_DEPTH))
                    begin
                        ref_count_reg <= ref_count_reg + CNW'(1);
                    end
                end
                else if (item.restart)
                begin
                    sum_reg <= '0;
                    qc_reg  <= '0;
                end
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end

            if (cmd.sqrt_start)
            begin
                sq_cnt_reg <= SCW'(SQN);
            end
            else if (sq_cnt_reg != '0)
            begin
                sq_cnt_reg <= sq_cnt_reg - SCW'(1);
            end

            if (cmd.post && !none_reg && (qc_reg < QCW'(QUERY_MAX)))
            begin
                sum_reg <= sum_add[DVD_W-1] ? '1 : sum_add[SUM_W-1:0];
                qc_reg  <= qc_reg + QCW'(1);
            end
            else if (cmd.div_start)
            begin
                sum_reg <= '0;
                qc_reg  <= '0;
            end

            if (cmd.div_start)
            begin
                dv_cnt_reg <= (qc_reg != '0) ? DCW'(DVD_W) : '0;
            end
            else if (dv_cnt_reg != '0)
            begin
                dv_cnt_reg <= dv_cnt_reg - DCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg   <= in_x;
            qy_reg   <= in_y;
            last_reg <= item.last;
            none_reg <= (ref_count_reg == '0);
        end

        rd_idx_reg <= scan_idx_reg;
        ab_idx_reg <= rd_idx_reg;
        sq_idx_reg <= ab_idx_reg;
        dx_reg     <= diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
        dy_reg     <= diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
        sqx_reg    <= SQ2'(dx_reg * dx_reg);
        sqy_reg    <= SQ2'(dy_reg * dy_reg);

        if (sq_v_reg && ((sq_idx_reg == '0) || (d2 < best_reg)))
        begin
            best_reg     <= d2;
            best_idx_reg <= sq_idx_reg;
        end

        if (cmd.sqrt_start)
        begin
            sq_src_reg  <= SQW'(best_reg);
            sq_root_reg <= '0;
            sq_rem_reg  <= '0;
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_src_reg <= {sq_src_reg[SQW-3:0], 2'b00};
            if (sq_rem_sh >= sq_trial)
            begin
                sq_rem_reg  <= sq_rem_sh - sq_trial;
                sq_root_reg <= {sq_root_reg[SQN-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= sq_rem_sh;
                sq_root_reg <= {sq_root_reg[SQN-2:0], 1'b0};
            end
        end

        if (cmd.post)
        begin
            dist_reg   <= dist_calc;
            pidx_reg   <= (qc_reg < QCW'(QUERY_MAX)) ? PIDX_W'(qc_reg)
                                                     : PIDX_W'(QUERY_MAX - 1);
            mvalid_reg <= 1'b0;
        end

        if (cmd.div_start)
        begin
            dv_quo_reg <= DVD_W'(sum_reg) + DVD_W'(qc_reg >> 1);
            dv_rem_reg <= '0;
            dv_div_reg <= qc_reg;
            mvalid_reg <= (qc_reg != '0);
        end
        else if (dv_cnt_reg != '0)
        begin
            if (dv_rem_sh >= {1'b0, dv_div_reg})
            begin
                dv_rem_reg <= dv_rem_sh - {1'b0, dv_div_reg};
                dv_quo_reg <= {dv_quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_rem_sh;
                dv_quo_reg <= {dv_quo_reg[DVD_W-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            result.distance      <= DIST_W'(dist_reg);
            result.nearest_index <= none_reg ? '0 : IDX_W'(best_idx_reg);
            result.point_index   <= pidx_reg;
            result.no_reference  <= none_reg;
            result.mean_distance <= mvalid_reg ? DIST_W'(dv_quo_reg) : '0;
            result.mean_valid    <= mvalid_reg;
        end
    end

    assign status.op        = item.op;
    assign status.ref_empty = (ref_count_reg == '0);
    assign status.scan_last = (CNW'(scan_idx_reg) == ref_count_reg - CNW'(1));
    assign status.pipe_busy = rd_v_reg | ab_v_reg | sq_v_reg;
    assign status.sqrt_done = (sq_cnt_reg == '0);
    assign status.last      = last_reg;
    assign status.div_done  = (dv_cnt_reg == '0);

endmodule

// ----- hw/rtl/nearest_point_mean_error.sv -----
// Top level of the nearest point mean error block.
// Depends on npme_pkg, npme_ctrl, npme_datapath.
//
//  channel | signals                            | transfer when
//  item    | item_valid, item_stall, item       | item_valid & !item_stall
//  result  | result_valid, result_stall, result | result_valid & !result_stall
//
// A load is taken without leaving the idle state. A query over a non-empty store makes
// one store read per corner, passes three pipeline stages and a one bit per cycle
// square root; the last query of a run also goes through the bit serial divider.
// Reset empties the store and clears sum and count; no clearing pass.
// A waiting result does not block the next item; a query finishing behind it waits.
module nearest_point_mean_error #(
    parameter int REF_DEPTH   = 16,
    parameter int QUERY_MAX   = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  npme_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output npme_pkg::result_t result
);
    import npme_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    npme_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    npme_datapath #(
        .REF_DEPTH   (REF_DEPTH),
        .QUERY_MAX   (QUERY_MAX),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// ----- hw/rtl/npme_checker.sv -----
// Port-level checks of the nearest point mean error block, bound to the top level.
// Depends on npme_pkg and assert_macros.svh.
`include "assert_macros.svh"

module npme_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input npme_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input npme_pkg::result_t result
);
    import npme_pkg::*;

    `NPME_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
    `NPME_ASSERT_NXT(a_query_busy, item_valid && !item_stall && item.op == OP_QUERY, item_stall)
    `NPME_ASSERT_IMP(a_empty_zero, result_valid && result.no_reference, result.distance == '0 && result.nearest_index == '0)
    `NPME_ASSERT_IMP(a_mean_zero, result_valid && !result.mean_valid, result.mean_distance == '0)

endmodule

bind nearest_point_mean_error npme_checker u_npme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- dv/npme_checker.sv -----
// Checker for the nearest point mean error block: watches both channels,
// predicts each query result and compares it field by field. Uses npme_pkg.
module npme_scoreboard
    import npme_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      pending,
    output int      query_seen,
    output int      load_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int RUN_MAX = 1024;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;

    logic signed [COORD_W-1:0] corner_x [DEPTH];
    logic signed [COORD_W-1:0] corner_y [DEPTH];
    int unsigned corner_count;
    logic [SUM_W-1:0] dist_sum;
    int unsigned run_count;
    result_t expected_q [$];

    function automatic longint unsigned isqrt_rounded(longint unsigned s);
        longint unsigned r;
        r = 0;
        for (int b = 17; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s)
                r = r | (64'd1 << b);
        if (s - r * r > r)
            r++;
        return r;
    endfunction

    task automatic predict_transfer(item_t it);
        result_t res;
        longint unsigned best, d2, dx, dy, nsum;
        longint signed px, py;
        res = '0;
        px = it.coord_x;
        py = it.coord_y;
        if (it.op == OP_LOAD) begin
            if (it.restart)
                corner_count = 0;
            if (corner_count < DEPTH) begin
                corner_x[corner_count] = it.coord_x;
                corner_y[corner_count] = it.coord_y;
                corner_count++;
            end
            load_seen++;
            return;
        end
        query_seen++;
        if (it.restart) begin
            dist_sum = '0;
            run_count = 0;
        end
        res.no_reference = (corner_count == 0);
        best = 0;
        if (corner_count != 0) begin
            for (int i = 0; i < corner_count; i++) begin
                dx = (px >= corner_x[i]) ? px - corner_x[i] : corner_x[i] - px;
                dy = (py >= corner_y[i]) ? py - corner_y[i] : corner_y[i] - py;
                d2 = dx * dx + dy * dy;
                if (i == 0 || d2 < best) begin
                    best = d2;
                    res.nearest_index = IDX_W'(i);
                end
            end
            res.distance = DIST_W'(isqrt_rounded(best));
        end
        res.point_index = PIDX_W'((run_count < RUN_MAX) ? run_count : RUN_MAX - 1);
        if (corner_count != 0 && run_count < RUN_MAX) begin
            nsum = dist_sum + res.distance;
            dist_sum = (nsum > SUM_SAT) ? SUM_SAT : SUM_W'(nsum);
            run_count++;
        end
        if (it.last) begin
            if (run_count != 0) begin
                res.mean_distance = DIST_W'((dist_sum + run_count / 2) / run_count);
                res.mean_valid = 1'b1;
            end
            dist_sum = '0;
            run_count = 0;
        end
        expected_q.insert(expected_q.size(), res);
    endtask

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t exp_r;
        if (!rst_n) begin
            corner_count = 0;
            dist_sum = '0;
            run_count = 0;
            expected_q.delete();
            fail_count = 0;
            query_seen = 0;
            load_seen = 0;
        end
        else begin
            if (item_valid && !item_stall)
                predict_transfer(item);
            if (result_valid && !result_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else begin
                    exp_r = expected_q.pop_front();
                    compare_field("distance", exp_r.distance, result.distance);
                    compare_field("nearest_index", exp_r.nearest_index,
                                  result.nearest_index);
                    compare_field("point_index", exp_r.point_index, result.point_index);
                    compare_field("no_reference", exp_r.no_reference, result.no_reference);
                    compare_field("mean_distance", exp_r.mean_distance,
                                  result.mean_distance);
                    compare_field("mean_valid", exp_r.mean_valid, result.mean_valid);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- dv/tb_nearest_point_mean_error.sv -----
// Testbench top for nearest_point_mean_error: directed then random stimulus,
// random idling on both sides. Depends on npme_pkg, nearest_point_mean_error and npme_scoreboard.
module tb_nearest_point_mean_error;
    timeunit 1ns;
    timeprecision 1ps;
    import npme_pkg::*;

    localparam int RANDOM_ITEMS = 690;
    localparam longint CYCLE_LIMIT = 2000000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      fail_count, pending, query_seen, load_seen;
    longint  cycles = 0;
    bit      quiet;

    nearest_point_mean_error u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    npme_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .fail_count(fail_count), .pending(pending),
        .query_seen(query_seen), .load_seen(load_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[nearest_point_mean_error] ERROR");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int gap;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 255)) - 16'd128);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // valid stays high after a transfer until the next call decides on a gap
    task automatic send_transfer(logic op, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y, logic rs, logic lst);
        item_t it;
        it.op = op;
        it.coord_x = x;
        it.coord_y = y;
        it.restart = rs;
        it.last = lst;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int ncorners, nq, mode, qi;
        quiet = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, empty run, extremes, ties, full store
        send_transfer(OP_QUERY, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
        send_transfer(OP_QUERY, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
        send_transfer(OP_LOAD, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
        send_transfer(OP_QUERY, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_transfer(OP_QUERY, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
        send_transfer(OP_LOAD, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
        send_transfer(OP_LOAD, 16'sh0000, 16'sh0000, 1'b1, 1'b0);
        send_transfer(OP_LOAD, 16'sh0002, 16'sh0000, 1'b0, 1'b0);
        send_transfer(OP_QUERY, 16'sh0001, 16'sh0000, 1'b1, 1'b0);
        send_transfer(OP_QUERY, 16'sh0001, 16'sh0001, 1'b0, 1'b1);
        for (int i = 0; i < 17; i++)
            send_transfer(OP_LOAD, 16'(i * 100), -16'(i * 37), i == 0, 1'b0);
        send_transfer(OP_QUERY, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1);

        // long run past the query limit, summed at the largest distances
        send_transfer(OP_LOAD, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
        for (int i = 0; i < 1030; i++)
            send_transfer(OP_QUERY, 16'sh7FFF, 16'sh7FFF, i == 0, i == 1029);

        // random runs: corner sets then query runs with random content
        qi = 0;
        while (qi < RANDOM_ITEMS)
        begin
            if (qi > RANDOM_ITEMS - 150)
                quiet = 1'b1;
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 3) != 0)
            begin
                ncorners = $urandom_range(0, 5) == 0 ? 16 : $urandom_range(1, 8);
                for (int i = 0; i < ncorners; i++)
                    send_transfer(OP_LOAD, rand_coord(mode), rand_coord(mode),
                                  i == 0, 1'($urandom));
                qi += ncorners;
            end
            nq = $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 12);
            for (int i = 0; i < nq; i++)
                send_transfer(OP_QUERY, rand_coord(mode), rand_coord(mode),
                              i == 0 ? 1'b1 : ($urandom_range(0, 15) == 0),
                              i == nq - 1 || $urandom_range(0, 20) == 0);
            if (nq == 0)
                send_transfer(OP_QUERY, rand_coord(2), rand_coord(2), 1'b1, 1'b1);
            qi += (nq == 0) ? 1 : nq;
        end
        item_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d query and %0d load transfers, store and run limits included.",
                 query_seen, load_seen);
        if (fail_count == 0 && pending == 0)
            $display("[nearest_point_mean_error] OK");
        else
            $display("[nearest_point_mean_error] ERROR");
        $finish;
    end

endmodule
